// ----- src/ame_pkg.sv -----
// shared types and constants for the accumulator machine execute block
`default_nettype none
package ame_pkg;

  // field widths fixed by the instruction format
  localparam int OP_W         = 4;
  localparam int SLOT_FIELD_W = 4;
  localparam int DATA_W       = 32;
  localparam int PC_W         = 11;
  localparam int STATUS_W     = 2;
  localparam int ERR_W        = 2;

  // defaults for the top level parameters
  localparam int DEF_SYMBOL_SLOTS  = 16;
  localparam int DEF_PROGRAM_DEPTH = 1024;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_PROGRAM_LENGTH = '0;

  // instruction codes
  typedef enum logic [OP_W-1:0] {
    OP_LDA  = 4'd0,
    OP_STA  = 4'd1,
    OP_ADD  = 4'd2,
    OP_SUB  = 4'd3,
    OP_J    = 4'd4,
    OP_COMP = 4'd5,
    OP_JEQ  = 4'd6,
    OP_JLT  = 4'd7,
    OP_JGT  = 4'd8,
    OP_RSUB = 4'd9,
    OP_END  = 4'd10
  } op_t;

  // compare status encodings (two bit signed)
  localparam logic [STATUS_W-1:0] ST_EQUAL   = 2'b00;
  localparam logic [STATUS_W-1:0] ST_GREATER = 2'b01;
  localparam logic [STATUS_W-1:0] ST_LESS    = 2'b11;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NO_OPERAND = 2'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_TARGET = 2'd2;

  // one decoded instruction
  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [SLOT_FIELD_W-1:0] operand_slot;
    logic [DATA_W-1:0]       literal_value;
    logic                    literal_valid;
  } item_t;

  // one execute result
  typedef struct packed {
    logic [PC_W-1:0]     next_pc;
    logic [DATA_W-1:0]   accumulator;
    logic [STATUS_W-1:0] compare_status;
    logic                halted;
    logic [ERR_W-1:0]    error_code;
  } result_t;

endpackage
`default_nettype wire

// ----- src/accumulator_machine_execute.sv -----
// Execute stage of a small accumulator machine: one decoded instruction per
// request, with accumulator, compare status, program counter, halt flag and
// a symbol store kept inside. A request is registered on entry, executed
// against the machine state, and its result is registered on exit, so a
// result passes through the input register and then the result register;
// one request can be accepted every cycle while result_stall does not hold
// the result register. The throughput is set by the loop from the
// accumulator and program counter registers through the execute logic back
// to themselves. The program length register sits at byte address 0 of the
// apb port; once halted, further requests return the held state.
`default_nettype none
module accumulator_machine_execute
  import ame_pkg::*;
#(
  parameter int SYMBOL_SLOTS  = DEF_SYMBOL_SLOTS,
  parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [APB_ADDR_W-1:0]   paddr,
  input  wire logic [APB_DATA_W-1:0]   pwdata,
  output logic      [APB_DATA_W-1:0]   prdata,
  output logic                         pready,
  input  wire logic                    item_valid,
  output logic                         item_stall,
  input  wire logic [OP_W-1:0]         operation,
  input  wire logic [SLOT_FIELD_W-1:0] operand_slot,
  input  wire logic [DATA_W-1:0]       literal_value,
  input  wire logic                    literal_valid,
  output logic                         result_valid,
  input  wire logic                    result_stall,
  output logic      [PC_W-1:0]         next_pc,
  output logic      [DATA_W-1:0]       accumulator_out,
  output logic      [STATUS_W-1:0]     compare_status,
  output logic                         halted,
  output logic      [ERR_W-1:0]        error_code
);

  logic      [PC_W-1:0] program_length;
  logic                 in_vld;
  logic                 in_vld_next;
  item_t                in_item;
  logic                 out_vld;
  result_t              out_res;
  result_t              exec_res;
  logic                 advance;
  logic                 fire;
  logic                 item_accept;

  ame_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .program_length (program_length)
  );

  ame_core #(
    .SYMBOL_SLOTS  (SYMBOL_SLOTS),
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .item           (in_item),
    .program_length (program_length),
    .result         (exec_res)
  );

  // pipeline control
  assign advance     = !out_vld || !result_stall;
  assign fire        = in_vld && advance;
  assign item_stall  = in_vld && !advance;
  assign item_accept = item_valid && !item_stall;

  always_comb begin
    in_vld_next = in_vld;
    if (item_accept) begin
      in_vld_next = 1'b1;
    end else if (advance) begin
      in_vld_next = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= in_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      in_item.operation     <= operation;
      in_item.operand_slot  <= operand_slot;
      in_item.literal_value <= literal_value;
      in_item.literal_valid <= literal_valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= exec_res;
    end
  end

  assign result_valid    = out_vld;
  assign next_pc         = out_res.next_pc;
  assign accumulator_out = out_res.accumulator;
  assign compare_status  = out_res.compare_status;
  assign halted          = out_res.halted;
  assign error_code      = out_res.error_code;

  // an empty input stage never holds off the sender
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_vld |-> !item_stall)
    else $error("input stalled with empty input register");

  // every error halts the machine
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    result_valid && (error_code != ERR_NONE) |-> halted)
    else $error("error reported without halt");

  // a running machine stays inside the program
  a_pc_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && !halted |-> (next_pc < program_length))
    else $error("next pc past program length while running");

  // status is one of the three codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (compare_status == ST_EQUAL) || (compare_status == ST_LESS) ||
                     (compare_status == ST_GREATER))
    else $error("bad compare status");

endmodule
`default_nettype wire

// ----- src/ame_cfg.sv -----
// apb register file holding the program length
`default_nettype none
module ame_cfg
  import ame_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [PC_W-1:0]       program_length
);

  logic hit;

  // register select from the word address
  assign hit    = (paddr[APB_ADDR_W-1:2] == REG_PROGRAM_LENGTH);
  assign pready = 1'b1;

  // write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (psel && penable && pwrite && hit) begin
      program_length <= pwdata[PC_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(APB_DATA_W-PC_W){1'b0}}, program_length};
    end
  end

endmodule
`default_nettype wire

// ----- src/ame_core.sv -----
// machine state, symbol store and combinational execute logic
`default_nettype none
module ame_core
  import ame_pkg::*;
#(
  parameter int SYMBOL_SLOTS  = DEF_SYMBOL_SLOTS,
  parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire item_t           item,
  input  wire logic [PC_W-1:0] program_length,
  output result_t              result
);

  // only slots reachable by the operand field get storage
  localparam int FIELD_SLOTS = 2 ** SLOT_FIELD_W;
  localparam int STORE_DEPTH = (SYMBOL_SLOTS < FIELD_SLOTS) ? SYMBOL_SLOTS : FIELD_SLOTS;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam logic [DATA_W-1:0] DEPTH_EXT = DATA_W'(PROGRAM_DEPTH);

  logic [DATA_W-1:0]   accumulator;
  logic [DATA_W-1:0]   accumulator_next;
  logic [STATUS_W-1:0] status_word;
  logic [STATUS_W-1:0] status_word_next;
  logic [PC_W-1:0]     program_counter;
  logic [PC_W-1:0]     program_counter_next;
  logic                stopped;
  logic                stopped_next;
  logic [DATA_W-1:0]   symbol_values [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] symbol_valid;

  logic [IDX_W-1:0]  slot_idx;
  logic [PC_W-1:0]   len;
  logic [DATA_W-1:0] len_ext;
  logic              have_val;
  logic [DATA_W-1:0] val;
  logic              store_en;
  logic              advance;
  logic              jump;
  logic [DATA_W-1:0] target;
  logic [PC_W-1:0]   npc;
  logic [ERR_W-1:0]  err;

  // operand slot wrapped onto the store depth
  always_comb begin
    slot_idx = '0;
    for (int k = 0; k < FIELD_SLOTS; k++) begin
      if (item.operand_slot == SLOT_FIELD_W'(k)) begin
        slot_idx = IDX_W'(k % STORE_DEPTH);
      end
    end
  end

  // program length clamped to the program depth
  always_comb begin
    len_ext = {{(DATA_W-PC_W){1'b0}}, program_length};
    len     = (len_ext > DEPTH_EXT) ? DEPTH_EXT[PC_W-1:0] : program_length;
  end

  // operand: stored symbol first, then the literal
  always_comb begin
    have_val = 1'b0;
    val      = item.literal_value;
    if (symbol_valid[slot_idx]) begin
      have_val = 1'b1;
      val      = symbol_values[slot_idx];
    end else if (item.literal_valid) begin
      have_val = 1'b1;
    end
  end

  // execute
  always_comb begin
    accumulator_next     = accumulator;
    status_word_next     = status_word;
    program_counter_next = program_counter;
    stopped_next         = stopped;
    store_en             = 1'b0;
    advance              = 1'b0;
    jump                 = 1'b0;
    npc                  = program_counter;
    err                  = ERR_NONE;
    target               = {{(DATA_W-PC_W){1'b0}}, program_counter} + DATA_W'(1);

    if (stopped || (program_counter >= len)) begin
      stopped_next = 1'b1;
    end else begin
      case (op_t'(item.operation))
        OP_LDA, OP_ADD, OP_SUB, OP_COMP: begin
          if (!have_val) begin
            stopped_next = 1'b1;
            err          = ERR_NO_OPERAND;
          end else begin
            advance = 1'b1;
            case (op_t'(item.operation))
              OP_LDA: accumulator_next = val;
              OP_ADD: accumulator_next = accumulator + val;
              OP_SUB: accumulator_next = accumulator - val;
              default: begin
                if (accumulator == val) begin
                  status_word_next = ST_EQUAL;
                end else if ($signed(accumulator) < $signed(val)) begin
                  status_word_next = ST_LESS;
                end else begin
                  status_word_next = ST_GREATER;
                end
              end
            endcase
          end
        end
        OP_STA: begin
          store_en = 1'b1;
          advance  = 1'b1;
        end
        OP_J: begin
          advance = 1'b1;
          jump    = 1'b1;
        end
        OP_JEQ: begin
          advance = 1'b1;
          jump    = (status_word == ST_EQUAL);
        end
        OP_JLT: begin
          advance = 1'b1;
          jump    = (status_word == ST_LESS);
        end
        OP_JGT: begin
          advance = 1'b1;
          jump    = (status_word == ST_GREATER);
        end
        OP_RSUB, OP_END: begin
          stopped_next = 1'b1;
        end
        default: begin
          advance = 1'b1;
        end
      endcase

      // taken jump needs a positive literal target
      if (advance && jump) begin
        if (!item.literal_valid) begin
          advance      = 1'b0;
          stopped_next = 1'b1;
          err          = ERR_NO_OPERAND;
        end else if (item.literal_value[DATA_W-1] || (item.literal_value == '0)) begin
          advance      = 1'b0;
          stopped_next = 1'b1;
          err          = ERR_BAD_TARGET;
        end else begin
          target = item.literal_value - DATA_W'(1);
        end
      end

      // next program counter, halting past the end
      if (advance) begin
        if (target >= {{(DATA_W-PC_W){1'b0}}, len}) begin
          stopped_next         = 1'b1;
          program_counter_next = len;
        end else begin
          program_counter_next = target[PC_W-1:0];
        end
        npc = program_counter_next;
      end
    end
  end

  assign result.next_pc        = npc;
  assign result.accumulator    = accumulator_next;
  assign result.compare_status = status_word_next;
  assign result.halted         = stopped_next;
  assign result.error_code     = err;

  // machine state
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= '0;
      status_word     <= ST_EQUAL;
      program_counter <= '0;
      stopped         <= 1'b0;
      symbol_valid    <= '0;
    end else if (fire) begin
      accumulator     <= accumulator_next;
      status_word     <= status_word_next;
      program_counter <= program_counter_next;
      stopped         <= stopped_next;
      if (store_en) begin
        symbol_valid[slot_idx] <= 1'b1;
      end
    end
  end

  // symbol values, no reset
  always_ff @(posedge clk) begin
    if (fire && store_en) begin
      symbol_values[slot_idx] <= accumulator;
    end
  end

endmodule
`default_nettype wire
